// ===== src/dks_pkg.sv =====
`default_nettype none
package dks_pkg;

  // Field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned SLOT_W  = 32;
  localparam int unsigned BLOCK_W = 24;
  localparam int unsigned OFF_W   = 8;
  localparam int unsigned KLEN_W  = 5;
  localparam int unsigned FILL_W  = 4;
  localparam int unsigned POS_W   = 32;

  // Default block span (offsets per block)
  localparam int unsigned BLOCK_SPAN_DEF = 256;

  // Longest k-mer held in one slot
  localparam logic [KLEN_W-1:0] KMER_MAX = 5'd16;

  // Recognized characters
  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

  // Base codes
  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  // Register map (word index)
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_KMER_LENGTH    = 2'd0;
  localparam logic [1:0] REG_REVERSE_ENABLE = 2'd1;
  localparam logic [1:0] REG_BLOCK_LIMIT    = 2'd2;

  // Reset values of the registers
  localparam logic [KLEN_W-1:0]  KLEN_RST  = 5'd16;
  localparam logic [BLOCK_W-1:0] LIMIT_RST = 24'hFFFFFF;

  typedef struct packed {
    logic [KLEN_W-1:0]  kmer_length;
    logic               reverse_enable;
    logic [BLOCK_W-1:0] block_limit;
  } cfg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] base_char;
    logic              new_sequence;
    logic [SEQ_W-1:0]  sequence_id;
  } item_t;

  typedef struct packed {
    logic               kmer_valid;
    logic [SLOT_W-1:0]  forward_slot;
    logic [SLOT_W-1:0]  reverse_slot;
    logic [BLOCK_W-1:0] block_index;
    logic [OFF_W-1:0]   block_offset;
    logic               block_advanced;
    logic [SEQ_W-1:0]   block_sequence;
    logic [POS_W-1:0]   block_start;
    logic               overflow_error;
  } result_t;

endpackage
`default_nettype wire

// ===== src/dks_cfg_regs.sv =====
`default_nettype none
module dks_cfg_regs
  import dks_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  logic [KLEN_W-1:0]  klen_q;
  logic               rev_q;
  logic [BLOCK_W-1:0] limit_q;
  logic               wr_en;
  logic [1:0]         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q  <= KLEN_RST;
      rev_q   <= 1'b0;
      limit_q <= LIMIT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_KMER_LENGTH:    klen_q  <= pwdata[KLEN_W-1:0];
        REG_REVERSE_ENABLE: rev_q   <= pwdata[0];
        REG_BLOCK_LIMIT:    limit_q <= pwdata[BLOCK_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_KMER_LENGTH:    prdata = {{(32-KLEN_W){1'b0}}, klen_q};
      REG_REVERSE_ENABLE: prdata = {31'd0, rev_q};
      REG_BLOCK_LIMIT:    prdata = {{(32-BLOCK_W){1'b0}}, limit_q};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o.kmer_length    = klen_q;
  assign cfg_o.reverse_enable = rev_q;
  assign cfg_o.block_limit    = limit_q;

endmodule
`default_nettype wire

// ===== src/dks_kmer_core.sv =====
`default_nettype none
module dks_kmer_core
  import dks_pkg::*;
#(
  parameter int unsigned BLOCK_SPAN = BLOCK_SPAN_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  item_t     item_i,
  input  cfg_t      cfg_i,
  output result_t   res_o
);

  localparam int unsigned SUM_W = OFF_W + 1;
  localparam logic [SUM_W-1:0] SPAN = SUM_W'(BLOCK_SPAN);

  // Rolling state
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [SLOT_W-1:0]  fwd_q, fwd_d;
  logic [SLOT_W-1:0]  rev_q, rev_d;
  logic [POS_W-1:0]   start_q, start_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic [BLOCK_W-1:0] block_q, block_d;
  logic               err_q, err_d;

  logic [KLEN_W-1:0]  k;
  logic [5:0]         two_k;
  logic [SLOT_W-1:0]  mask;
  logic               code_ok;
  logic [1:0]         code;
  logic [FILL_W-1:0]  fill_in;
  logic [SLOT_W-1:0]  fwd_in, rev_in;
  logic [POS_W-1:0]   start_in, start_nx;
  logic [KLEN_W-1:0]  fill_inc;
  logic               emit;
  logic [SUM_W-1:0]   off_sum, off_wrap;
  logic               wrap;
  logic [BLOCK_W:0]   block_inc;
  logic               full;

  // Clamp k to 1..16, build the 2k-bit mask
  always_comb begin
    k = cfg_i.kmer_length;
    if (k == '0) k = KLEN_W'(1);
    if (k > KMER_MAX) k = KMER_MAX;
  end
  assign two_k = {k, 1'b0};
  assign mask  = {SLOT_W{1'b1}} >> (6'd32 - two_k);

  // Character decode
  always_comb begin
    code_ok = 1'b1;
    code    = CODE_A;
    case (item_i.base_char)
      CHAR_A:  code = CODE_A;
      CHAR_C:  code = CODE_C;
      CHAR_G:  code = CODE_G;
      CHAR_T:  code = CODE_T;
      default: code_ok = 1'b0;
    endcase
  end

  // New sequence clears the window first
  assign fill_in  = item_i.new_sequence ? '0 : fill_q;
  assign fwd_in   = item_i.new_sequence ? '0 : fwd_q;
  assign rev_in   = item_i.new_sequence ? '0 : rev_q;
  assign start_in = item_i.new_sequence ? '0 : start_q;
  assign fill_inc = {1'b0, fill_in} + KLEN_W'(1);

  // Window update and offset advance
  always_comb begin
    emit     = 1'b0;
    fwd_d    = '0;
    rev_d    = '0;
    fill_d   = '0;
    start_nx = start_in;
    off_sum  = {1'b0, off_q};
    if (code_ok) begin
      fwd_d = ((fwd_in >> 2) | (SLOT_W'(code) << (two_k - 6'd2))) & mask;
      rev_d = ((rev_in << 2) | SLOT_W'(CODE_T - code)) & mask;
      if (fill_inc >= k) begin
        emit     = 1'b1;
        fill_d   = FILL_W'(k - KLEN_W'(1));
        start_nx = start_in + POS_W'(1);
        off_sum  = {1'b0, off_q} + SUM_W'(1);
      end else begin
        fill_d = fill_inc[FILL_W-1:0];
      end
    end else begin
      start_nx = start_in + POS_W'(fill_inc);
      off_sum  = {1'b0, off_q} + SUM_W'(fill_inc);
    end
  end

  // Block bookkeeping; the sum stays below twice the span
  assign wrap      = off_sum >= SPAN;
  assign off_wrap  = wrap ? off_sum - SPAN : off_sum;
  assign block_inc = {1'b0, block_q} + (BLOCK_W+1)'(1);
  assign full      = block_inc >= {1'b0, cfg_i.block_limit};

  always_comb begin
    block_d = block_q;
    err_d   = err_q;
    off_d   = off_wrap[OFF_W-1:0];
    start_d = start_nx;
    if (wrap) begin
      if (full) err_d = 1'b1;
      else      block_d = block_inc[BLOCK_W-1:0];
    end
  end

  // Result fields
  always_comb begin
    res_o = '0;
    res_o.kmer_valid = emit;
    if (emit) begin
      res_o.forward_slot = fwd_d;
      res_o.reverse_slot = cfg_i.reverse_enable ? rev_d : '0;
      res_o.block_index  = block_q;
      res_o.block_offset = off_q;
    end
    if (wrap && !full) begin
      res_o.block_advanced = 1'b1;
      res_o.block_sequence = item_i.sequence_id;
      res_o.block_start    = start_nx - POS_W'(off_wrap);
    end
    res_o.overflow_error = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      fwd_q   <= '0;
      rev_q   <= '0;
      start_q <= '0;
      off_q   <= '0;
      block_q <= '0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      fill_q  <= fill_d;
      fwd_q   <= fwd_d;
      rev_q   <= rev_d;
      start_q <= start_d;
      off_q   <= off_d;
      block_q <= block_d;
      err_q   <= err_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/dna_kmer_slot_stream.sv =====
// Rolling 2-bit k-mer slot stream with block/offset bookkeeping.
// Each accepted item is held in the input register, then moves into the result register.
// Throughput: one item per cycle while the output is not stalled; the window and block state update on each step.
// Stalls at the output back up through the input register to in_ready_o.
// Reset (rst_ni low, async) clears pipeline valids, window and block state,
// and loads the register defaults: kmer_length 16, reverse off, limit max.
`default_nettype none
module dna_kmer_slot_stream
  import dks_pkg::*;
#(
  parameter int unsigned BLOCK_SPAN = BLOCK_SPAN_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // Input items
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [CHAR_W-1:0]  base_char_i,
  input  wire logic               new_sequence_i,
  input  wire logic [SEQ_W-1:0]   sequence_id_i,
  // Result items
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    kmer_valid_o,
  output logic      [SLOT_W-1:0]  forward_slot_o,
  output logic      [SLOT_W-1:0]  reverse_slot_o,
  output logic      [BLOCK_W-1:0] block_index_o,
  output logic      [OFF_W-1:0]   block_offset_o,
  output logic                    block_advanced_o,
  output logic      [SEQ_W-1:0]   block_sequence_o,
  output logic      [POS_W-1:0]   block_start_o,
  output logic                    overflow_error_o
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid_q, item_valid_d;
  result_t res, res_q;
  logic    res_valid_q, res_valid_d;
  logic    res_take;
  logic    step;
  logic    in_acc;

  dks_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: result reg frees up, input reg moves into it
  assign res_take   = !res_valid_q || out_ready_i;
  assign step       = item_valid_q && res_take;
  assign in_ready_o = !item_valid_q || res_take;
  assign in_acc     = in_valid_i && in_ready_o;

  assign item_valid_d = in_acc ? 1'b1 : (step ? 1'b0 : item_valid_q);
  assign res_valid_d  = step ? 1'b1 : (out_ready_i ? 1'b0 : res_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.base_char    <= base_char_i;
      item_q.new_sequence <= new_sequence_i;
      item_q.sequence_id  <= sequence_id_i;
    end
  end

  dks_kmer_core #(
    .BLOCK_SPAN (BLOCK_SPAN)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (step) res_q <= res;
  end

  assign out_valid_o      = res_valid_q;
  assign kmer_valid_o     = res_q.kmer_valid;
  assign forward_slot_o   = res_q.forward_slot;
  assign reverse_slot_o   = res_q.reverse_slot;
  assign block_index_o    = res_q.block_index;
  assign block_offset_o   = res_q.block_offset;
  assign block_advanced_o = res_q.block_advanced;
  assign block_sequence_o = res_q.block_sequence;
  assign block_start_o    = res_q.block_start;
  assign overflow_error_o = res_q.overflow_error;

endmodule
`default_nettype wire

// ===== test/dna_kmer_slot_stream_test.sv =====
module dna_kmer_slot_stream_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dks_pkg::*;

  localparam int unsigned SPAN        = BLOCK_SPAN_DEF;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned HOLD_AT     = 300;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam result_t     NO_SLOT     = '0;

  // One directed row: either a register write or an item
  typedef struct {
    bit          cfg_write;
    logic [1:0]  reg_sel;
    logic [31:0] reg_val;
    item_t       it;
    bit          typed;
    result_t     want;
  } stim_row_t;

  typedef struct {
    logic [KLEN_W-1:0]  klen;
    logic               rev;
    logic [BLOCK_W-1:0] limit;
    int unsigned        items;
  } phase_t;

  // Random phases: length extremes and out-of-range lengths, tight block limits last
  phase_t phases [8] = '{
    '{5'd1,  1'b1, 24'hFFFFFF, 260},
    '{5'd16, 1'b1, 24'hFFFFFF, 260},
    '{5'd0,  1'b0, 24'd100,    200},
    '{5'd31, 1'b1, 24'h800000, 200},
    '{5'd7,  1'b1, 24'h000FFF, 200},
    '{5'd12, 1'b0, 24'hFFFFFF, 200},
    '{5'd3,  1'b1, 24'd1,      320},
    '{5'd16, 1'b1, 24'd0,      300}
  };

  logic [CHAR_W-1:0] acgt [4] = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [ADDR_W-1:0]  paddr          = '0;
  logic [31:0]        pwdata         = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [CHAR_W-1:0]  base_char_i    = '0;
  logic               new_sequence_i = 1'b0;
  logic [SEQ_W-1:0]   sequence_id_i  = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic               kmer_valid_o;
  logic [SLOT_W-1:0]  forward_slot_o;
  logic [SLOT_W-1:0]  reverse_slot_o;
  logic [BLOCK_W-1:0] block_index_o;
  logic [OFF_W-1:0]   block_offset_o;
  logic               block_advanced_o;
  logic [SEQ_W-1:0]   block_sequence_o;
  logic [POS_W-1:0]   block_start_o;
  logic               overflow_error_o;

  dna_kmer_slot_stream #(
    .BLOCK_SPAN(SPAN)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .base_char_i     (base_char_i),
    .new_sequence_i  (new_sequence_i),
    .sequence_id_i   (sequence_id_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kmer_valid_o    (kmer_valid_o),
    .forward_slot_o  (forward_slot_o),
    .reverse_slot_o  (reverse_slot_o),
    .block_index_o   (block_index_o),
    .block_offset_o  (block_offset_o),
    .block_advanced_o(block_advanced_o),
    .block_sequence_o(block_sequence_o),
    .block_start_o   (block_start_o),
    .overflow_error_o(overflow_error_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow registers and window/block state of the slot predictor
  cfg_t               shadow_cfg = '{KLEN_RST, 1'b0, LIMIT_RST};
  int unsigned        fill_held  = 0;
  logic [31:0]        fwd_win    = '0;
  logic [31:0]        rev_win    = '0;
  logic [31:0]        win_start  = '0;
  logic [OFF_W-1:0]   blk_off    = '0;
  logic [BLOCK_W-1:0] blk_num    = '0;
  logic               ovf_seen   = 1'b0;

  result_t     slots_due [$];
  stim_row_t   plan [$];
  int unsigned slot_errors  = 0;
  int unsigned sent_n       = 0;
  int unsigned got_n        = 0;
  int unsigned quiet_cycles = 0;
  bit          send_busy    = 1'b0;
  bit          recv_busy    = 1'b0;

  // Rolls one character into the window and returns the slot it produces
  function automatic result_t roll_kmer(input item_t it);
    result_t     r;
    int unsigned k;
    int unsigned off;
    logic [31:0] mask;
    logic [31:0] c;
    logic        hit;
    r = '0;
    k = shadow_cfg.kmer_length;
    if (k == 0) k = 1;
    if (k > KMER_MAX) k = KMER_MAX;
    mask = 32'((64'd1 << (2 * k)) - 64'd1);
    if (it.new_sequence) begin
      fill_held = 0;
      win_start = '0;
      fwd_win   = '0;
      rev_win   = '0;
    end
    off = blk_off;
    hit = 1'b1;
    c   = '0;
    case (it.base_char)
      CHAR_A:  c = 32'(CODE_A);
      CHAR_C:  c = 32'(CODE_C);
      CHAR_G:  c = 32'(CODE_G);
      CHAR_T:  c = 32'(CODE_T);
      default: hit = 1'b0;
    endcase
    if (hit) begin
      fwd_win = ((fwd_win >> 2) | (c << (2 * k - 2))) & mask;
      rev_win = ((rev_win << 2) | (32'd3 - c)) & mask;
      if (fill_held + 1 >= k) begin
        r.kmer_valid   = 1'b1;
        r.forward_slot = fwd_win;
        r.reverse_slot = shadow_cfg.reverse_enable ? rev_win : '0;
        r.block_index  = blk_num;
        r.block_offset = blk_off;
        win_start      = win_start + 1;
        off            = off + 1;
        fill_held      = k - 1;
      end else begin
        fill_held = fill_held + 1;
      end
    end else begin
      // held bases plus the bad one are skipped
      win_start = win_start + fill_held + 1;
      off       = off + fill_held + 1;
      fill_held = 0;
      fwd_win   = '0;
      rev_win   = '0;
    end
    if (off >= SPAN) begin
      off = off % SPAN;
      if (32'(blk_num) + 1 >= 32'(shadow_cfg.block_limit)) begin
        ovf_seen = 1'b1;
      end else begin
        blk_num          = blk_num + BLOCK_W'(1);
        r.block_advanced = 1'b1;
        r.block_sequence = it.sequence_id;
        r.block_start    = win_start - off;
      end
    end
    blk_off          = off[OFF_W-1:0];
    r.overflow_error = ovf_seen;
    return r;
  endfunction

  function automatic void add_item(input logic [CHAR_W-1:0] ch, input logic ns,
                                   input logic [SEQ_W-1:0] sid, input bit typed,
                                   input result_t want);
    stim_row_t row;
    row           = '{default: '0};
    row.it        = '{ch, ns, sid};
    row.typed     = typed;
    row.want      = want;
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [1:0] sel, input logic [31:0] val);
    stim_row_t row;
    row           = '{default: '0};
    row.cfg_write = 1'b1;
    row.reg_sel   = sel;
    row.reg_val   = val;
    plan.push_back(row);
  endfunction

  task automatic flag_field(input string what, input logic [31:0] got,
                            input logic [31:0] want);
    $display("result %0d: %s is %0h, expected %0h", got_n, what, got, want);
    slot_errors++;
  endtask

  // Sends one item and books its expected slot at the accepting edge
  task automatic drive_item(input item_t it, input bit typed, input result_t want);
    int unsigned gap;
    result_t     due;
    if (sent_n % 32 == 0) send_busy = 1'($urandom_range(0, 1));
    gap = send_busy ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    base_char_i    <= it.base_char;
    new_sequence_i <= it.new_sequence;
    sequence_id_i  <= it.sequence_id;
    do @(posedge clk_i); while (!in_ready_o);
    due = roll_kmer(it);
    slots_due.push_back(typed ? want : due);
    sent_n++;
  endtask

  // Register write once the pipeline has drained
  task automatic write_reg(input logic [1:0] sel, input logic [31:0] val);
    in_valid_i <= 1'b0;
    if (psel) @(posedge clk_i);
    while (slots_due.size() != 0) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      REG_KMER_LENGTH:    shadow_cfg.kmer_length    = val[KLEN_W-1:0];
      REG_REVERSE_ENABLE: shadow_cfg.reverse_enable = val[0];
      REG_BLOCK_LIMIT:    shadow_cfg.block_limit    = val[BLOCK_W-1:0];
      default: ;
    endcase
  endtask

  // Result side: random stalls, one long hold-off, field-by-field compare
  initial begin
    int unsigned gap;
    result_t     seen;
    result_t     want;
    wait (rst_ni);
    forever begin
      if (got_n % 32 == 0) recv_busy = 1'($urandom_range(0, 1));
      gap = recv_busy ? $urandom_range(0, 14) : 0;
      if (got_n == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      seen = {kmer_valid_o, forward_slot_o, reverse_slot_o, block_index_o, block_offset_o,
              block_advanced_o, block_sequence_o, block_start_o, overflow_error_o};
      if (slots_due.size() == 0) begin
        flag_field("unexpected item", 32'(seen.kmer_valid), '0);
      end else begin
        want = slots_due.pop_front();
        if (seen.kmer_valid !== want.kmer_valid)
          flag_field("kmer_valid", 32'(seen.kmer_valid), 32'(want.kmer_valid));
        if (seen.forward_slot !== want.forward_slot)
          flag_field("forward_slot", seen.forward_slot, want.forward_slot);
        if (seen.reverse_slot !== want.reverse_slot)
          flag_field("reverse_slot", seen.reverse_slot, want.reverse_slot);
        if (seen.block_index !== want.block_index)
          flag_field("block_index", 32'(seen.block_index), 32'(want.block_index));
        if (seen.block_offset !== want.block_offset)
          flag_field("block_offset", 32'(seen.block_offset), 32'(want.block_offset));
        if (seen.block_advanced !== want.block_advanced)
          flag_field("block_advanced", 32'(seen.block_advanced), 32'(want.block_advanced));
        if (seen.block_sequence !== want.block_sequence)
          flag_field("block_sequence", 32'(seen.block_sequence), 32'(want.block_sequence));
        if (seen.block_start !== want.block_start)
          flag_field("block_start", seen.block_start, want.block_start);
        if (seen.overflow_error !== want.overflow_error)
          flag_field("overflow_error", 32'(seen.overflow_error), 32'(want.overflow_error));
      end
      got_n++;
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("dna_kmer_slot_stream: mismatch");
      $finish;
    end
  end

  initial begin
    item_t            it;
    int unsigned      seq_left;
    logic [SEQ_W-1:0] cur_sid;
    seq_left = 0;
    cur_sid  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset defaults, bad characters, short and out-of-range lengths
    add_item(CHAR_A, 1'b1, 16'h0000, 1'b1, NO_SLOT);
    add_item(CHAR_C, 1'b0, 16'hFFFF, 1'b1, NO_SLOT);
    add_item(8'hFF,  1'b0, 16'hFFFF, 1'b1, NO_SLOT);
    add_item(8'h00,  1'b0, 16'h0000, 1'b1, NO_SLOT);
    add_item(8'h61,  1'b0, 16'h5A5A, 1'b1, NO_SLOT);  // lowercase is not a base
    add_cfg(REG_KMER_LENGTH, 32'd2);
    add_cfg(REG_REVERSE_ENABLE, 32'd1);
    add_item(CHAR_A, 1'b1, 16'h1234, 1'b1, NO_SLOT);
    add_item(CHAR_C, 1'b0, 16'h1234, 1'b0, NO_SLOT);
    add_item(CHAR_G, 1'b0, 16'h1234, 1'b0, NO_SLOT);
    add_item(CHAR_T, 1'b0, 16'h1234, 1'b0, NO_SLOT);
    add_item(CHAR_T, 1'b1, 16'hA5A5, 1'b1, NO_SLOT);  // restart mid-window
    add_item(8'h4E,  1'b0, 16'hA5A5, 1'b1, NO_SLOT);
    add_cfg(REG_KMER_LENGTH, 32'd1);
    add_item(CHAR_A, 1'b0, 16'hA5A5, 1'b0, NO_SLOT);
    add_item(CHAR_C, 1'b0, 16'hA5A5, 1'b0, NO_SLOT);
    add_item(CHAR_G, 1'b0, 16'hA5A5, 1'b0, NO_SLOT);
    add_item(CHAR_T, 1'b0, 16'hA5A5, 1'b0, NO_SLOT);
    add_cfg(REG_KMER_LENGTH, 32'd0);                 // behaves as one
    add_item(CHAR_G, 1'b0, 16'hA5A5, 1'b0, NO_SLOT);
    add_cfg(REG_KMER_LENGTH, 32'd31);                // clamps to sixteen
    add_item(CHAR_C, 1'b0, 16'hA5A5, 1'b0, NO_SLOT);
    add_item(CHAR_A, 1'b0, 16'hA5A5, 1'b0, NO_SLOT);
    foreach (plan[i]) begin
      if (plan[i].cfg_write) write_reg(plan[i].reg_sel, plan[i].reg_val);
      else drive_item(plan[i].it, plan[i].typed, plan[i].want);
    end

    // Random sequences, mostly clean bases with some breaks and restarts
    foreach (phases[p]) begin
      write_reg(REG_KMER_LENGTH, 32'(phases[p].klen));
      write_reg(REG_REVERSE_ENABLE, 32'(phases[p].rev));
      write_reg(REG_BLOCK_LIMIT, 32'(phases[p].limit));
      repeat (phases[p].items) begin
        it.new_sequence = 1'b0;
        if (seq_left == 0) begin
          seq_left        = $urandom_range(4, 60);
          cur_sid         = SEQ_W'($urandom_range(0, 16'hFFFF));
          it.new_sequence = 1'b1;
        end
        seq_left--;
        it.sequence_id = cur_sid;
        if ($urandom_range(0, 99) < 93) it.base_char = acgt[2'($urandom_range(0, 3))];
        else it.base_char = CHAR_W'($urandom_range(0, 255));
        drive_item(it, 1'b0, NO_SLOT);
      end
    end

    in_valid_i <= 1'b0;
    while (slots_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (slot_errors == 0) begin
      $display("dna_kmer_slot_stream: match");
    end else begin
      $display("dna_kmer_slot_stream: mismatch");
    end
    $finish;
  end

endmodule
